FILE: rtl/sstq_pkg.sv
`default_nettype none
package sstq_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int MAX_ADDRESSABLE = 32;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_BIND  = 3'd3;
  localparam logic [2:0] OP_ARM   = 3'd4;

  localparam logic [1:0] KIND_GRANT   = 2'd0;
  localparam logic [1:0] KIND_NOFREE  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;

  typedef struct packed {
    logic load;
    logic tick_inc;
    logic alloc_do;
    logic free_do;
    logic bind_do;
    logic wr_dl;
    logic arm_head;
    logic start_walk;
    logic adv;
    logic wr_link_prev;
    logic wr_link_self;
    logic emit_exp;
    logic finish_tick;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       usable;
    logic [1:0] idx_st;
    logic       due;
    logic       head_zero;
    logic       ins_head;
    logic       walk_hit;
    logic       cont;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/sstq_ram.sv
`default_nettype none
module sstq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/sstq_ctrl.sv
`default_nettype none
module sstq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sstq_pkg::sts_t sts,
  output sstq_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_AOUT, S_W_RL, S_W_RD, S_W_CMP, S_W_WS,
    S_TCHK, S_T_RL, S_T_RD, S_T_CMP
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (sts.op)
          sstq_pkg::OP_TICK: begin
            cmd.tick_inc = 1'b1;
            state_next   = S_TCHK;
          end
          sstq_pkg::OP_ALLOC: state_next = S_AOUT;
          sstq_pkg::OP_FREE:
            cmd.free_do = sts.usable && (sts.idx_st == sstq_pkg::ST_ALLOC);
          sstq_pkg::OP_BIND: cmd.bind_do = sts.usable;
          sstq_pkg::OP_ARM: begin
            if (sts.usable && (sts.idx_st != sstq_pkg::ST_ARMED)) begin
              cmd.wr_dl = 1'b1;
              if (sts.ins_head) begin
                cmd.arm_head = 1'b1;
              end else begin
                cmd.start_walk = 1'b1;
                state_next     = S_W_RL;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_AOUT: begin
        if (sts.out_free) begin
          cmd.alloc_do = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_W_RL: state_next = S_W_RD;
      S_W_RD: state_next = S_W_CMP;
      S_W_CMP: begin
        if (sts.walk_hit) begin
          cmd.wr_link_prev = 1'b1;
          state_next       = S_W_WS;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_W_RL;
        end
      end
      S_W_WS: begin
        cmd.wr_link_self = 1'b1;
        state_next       = S_IDLE;
      end
      S_TCHK: begin
        if (sts.due && !sts.head_zero) begin
          cmd.start_walk = 1'b1;
          state_next     = S_T_RL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_T_RL: state_next = S_T_RD;
      S_T_RD: state_next = S_T_CMP;
      S_T_CMP: begin
        if (sts.out_free) begin
          cmd.emit_exp = 1'b1;
          if (sts.cont) begin
            cmd.adv    = 1'b1;
            state_next = S_T_RL;
          end else begin
            cmd.finish_tick = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sstq_dp.sv
`default_nettype none
module sstq_dp #(
  parameter int SLOT_COUNT = sstq_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sstq_pkg::cmd_t      cmd,
  output sstq_pkg::sts_t           sts,
  input  wire logic [2:0]          operation,
  input  wire logic [4:0]          slot_index,
  input  wire logic [3:0]          destination,
  input  wire logic signed [31:0]  payload,
  input  wire logic [31:0]         delay_ticks,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               result_kind,
  output logic [4:0]               result_slot,
  output logic [3:0]               result_destination,
  output logic signed [31:0]       result_payload,
  output logic                     last_of_run
);

  localparam int ADDR = (SLOT_COUNT < sstq_pkg::MAX_ADDRESSABLE) ?
                        SLOT_COUNT : sstq_pkg::MAX_ADDRESSABLE;
  localparam int AW = $clog2(ADDR);
  localparam int NW = $clog2(ADDR + 1);

  logic [2:0]        op;
  logic [4:0]        idx;
  logic [3:0]        dest_in;
  logic [31:0]       pay_in;
  logic [31:0]       dl_new;
  logic [31:0]       tick_count;
  logic [31:0]       earliest;
  logic [AW-1:0]     head;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     nxt;
  logic [NW-1:0]     n;
  logic [1:0]        status [ADDR];

  logic [AW-1:0]     idx_a;
  logic [AW-1:0]     link_rdata;
  logic [31:0]       dl_rdata;
  logic [31:0]       dl_eff;
  logic [3:0]        dest_rdata;
  logic [31:0]       pay_rdata;
  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [AW-1:0]     link_wdata;
  logic              free_found;
  logic [AW-1:0]     free_low;
  logic              usable;

  assign idx_a  = idx[AW-1:0];
  assign usable = (idx != 5'd0) && ({1'b0, idx} < 6'(ADDR));
  assign dl_eff = (nxt == '0) ? sstq_pkg::ALL_ONES : dl_rdata;

  always_comb begin
    free_found = 1'b0;
    free_low   = '0;
    for (int i = ADDR - 1; i >= 1; i--) begin
      if (status[i] == sstq_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_low   = AW'(i);
      end
    end
  end

  always_comb begin
    sts.op        = op;
    sts.usable    = usable;
    sts.idx_st    = status[idx_a];
    sts.due       = (earliest <= tick_count);
    sts.head_zero = (head == '0);
    sts.ins_head  = (dl_new <= earliest);
    sts.walk_hit  = (dl_new <= dl_eff);
    sts.cont      = (nxt != '0) && (({1'b0, n} + (NW+1)'(1)) < (NW+1)'(ADDR - 1)) &&
                    (dl_eff <= earliest);
    sts.out_free  = !out_valid || !out_stall;
  end

  assign link_we    = cmd.arm_head || cmd.wr_link_prev || cmd.wr_link_self;
  assign link_waddr = cmd.wr_link_prev ? cur : idx_a;
  assign link_wdata = cmd.arm_head ? head : (cmd.wr_link_prev ? idx_a : nxt);

  sstq_ram #(.WIDTH(AW), .DEPTH(ADDR)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur), .rdata(link_rdata)
  );

  sstq_ram #(.WIDTH(32), .DEPTH(ADDR)) u_deadline (
    .clk(clk), .we(cmd.wr_dl), .waddr(idx_a), .wdata(dl_new),
    .raddr(link_rdata), .rdata(dl_rdata)
  );

  sstq_ram #(.WIDTH(4), .DEPTH(ADDR)) u_dest (
    .clk(clk), .we(cmd.bind_do), .waddr(idx_a), .wdata(dest_in),
    .raddr(cur), .rdata(dest_rdata)
  );

  sstq_ram #(.WIDTH(32), .DEPTH(ADDR)) u_payload (
    .clk(clk), .we(cmd.bind_do), .waddr(idx_a), .wdata(pay_in),
    .raddr(cur), .rdata(pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= operation;
      idx     <= slot_index;
      dest_in <= destination;
      pay_in  <= payload;
      dl_new  <= tick_count + delay_ticks;
    end
    if (cmd.start_walk) begin
      cur <= head;
      n   <= '0;
    end else if (cmd.adv) begin
      cur <= nxt;
    end
    if (cmd.emit_exp) begin
      n <= n + NW'(1);
    end
    nxt <= link_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      earliest   <= sstq_pkg::ALL_ONES;
      head       <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < ADDR; i++) begin
        status[i] <= (i == 0) ? sstq_pkg::ST_ARMED : sstq_pkg::ST_FREE;
      end
    end else begin
      if (cmd.tick_inc) begin
        tick_count <= tick_count + 32'd1;
      end
      if (cmd.arm_head) begin
        head     <= idx_a;
        earliest <= dl_new;
      end
      if (cmd.finish_tick) begin
        head     <= nxt;
        earliest <= dl_eff;
      end
      for (int i = 1; i < ADDR; i++) begin
        if (cmd.alloc_do && free_found && (free_low == AW'(i))) begin
          status[i] <= sstq_pkg::ST_ALLOC;
        end
        if (cmd.free_do && (idx_a == AW'(i))) begin
          status[i] <= sstq_pkg::ST_FREE;
        end
        if ((cmd.arm_head || cmd.wr_link_prev) && (idx_a == AW'(i))) begin
          status[i] <= sstq_pkg::ST_ARMED;
        end
        if (cmd.emit_exp && (cur == AW'(i))) begin
          status[i] <= sstq_pkg::ST_ALLOC;
        end
      end
      if (cmd.alloc_do || cmd.emit_exp) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_do) begin
      result_kind        <= free_found ? sstq_pkg::KIND_GRANT : sstq_pkg::KIND_NOFREE;
      result_slot        <= free_found ? 5'(free_low) : 5'd0;
      result_destination <= 4'd0;
      result_payload     <= 32'sd0;
      last_of_run        <= 1'b1;
    end else if (cmd.emit_exp) begin
      result_kind        <= sstq_pkg::KIND_EXPIRED;
      result_slot        <= 5'(cur);
      result_destination <= dest_rdata;
      result_payload     <= pay_rdata;
      last_of_run        <= !sts.cont;
    end
  end

  a_empty_list_latest: assert property (@(posedge clk) disable iff (rst)
    (head == '0) |-> (earliest == sstq_pkg::ALL_ONES))
    else $error("empty list with finite earliest deadline");

  a_tick_only_on_cmd: assert property (@(posedge clk) disable iff (rst)
    !cmd.tick_inc |=> $stable(tick_count))
    else $error("tick count moved without a tick");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(cmd.alloc_do || cmd.emit_exp))
    else $error("result overwritten while held");

endmodule
`default_nettype wire

FILE: rtl/sorted_software_timer_queue_top.sv
// Arm: written straight in at the list head, else the list is walked one entry at a time from the head.
// Tick expiry: each expired slot passes through the registered link and deadline reads.
// One transfer is taken at a time.
// Reset (rst, synchronous): all slots free, sentinel armed, list empty,
// tick count zero; slot RAMs are not cleared.
`default_nettype none
module sorted_software_timer_queue_top #(
  parameter int SLOT_COUNT = sstq_pkg::SLOT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [4:0]         slot_index,
  input  wire logic [3:0]         destination,
  input  wire logic signed [31:0] payload,
  input  wire logic [31:0]        delay_ticks,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              result_kind,
  output logic [4:0]              result_slot,
  output logic [3:0]              result_destination,
  output logic signed [31:0]      result_payload,
  output logic                    last_of_run
);

  sstq_pkg::cmd_t cmd;
  sstq_pkg::sts_t sts;

  sstq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  sstq_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(operation), .slot_index(slot_index), .destination(destination),
    .payload(payload), .delay_ticks(delay_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .result_slot(result_slot),
    .result_destination(result_destination), .result_payload(result_payload),
    .last_of_run(last_of_run)
  );

endmodule
`default_nettype wire

FILE: sim/sorted_software_timer_queue_top_tb.sv
`default_nettype none
module sorted_software_timer_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class timer_scoreboard;
    typedef struct {
      bit [1:0]  kind;
      bit [4:0]  slot;
      bit [3:0]  dest;
      bit [31:0] pay;
      bit        last;
    } expiry_t;

    bit [1:0]  status[32];
    bit [31:0] deadline[32];
    bit [3:0]  dest_mem[32];
    bit [31:0] pay_mem[32];
    bit [4:0]  link[32];
    bit [4:0]  head;
    bit [31:0] earliest;
    bit [31:0] ticks;
    expiry_t   awaited_q[$];
    int        errors;

    function new();
      foreach (status[i]) begin
        status[i] = sstq_pkg::ST_FREE;
        deadline[i] = 0;
        link[i] = 0;
      end
      status[0] = sstq_pkg::ST_ARMED;
      deadline[0] = sstq_pkg::ALL_ONES;
      head = 0;
      earliest = sstq_pkg::ALL_ONES;
      ticks = 0;
      errors = 0;
    endfunction

    function void push(bit [1:0] k, bit [4:0] s, bit [3:0] d, bit [31:0] p, bit l);
      expiry_t e;
      e.kind = k;
      e.slot = s;
      e.dest = d;
      e.pay = p;
      e.last = l;
      awaited_q.push_back(e);
    endfunction

    function void insert_timer(bit [4:0] s, bit [31:0] delay);
      bit [31:0] d;
      bit [4:0]  prev;
      bit [4:0]  nxt;
      d = ticks + delay;
      deadline[s] = d;
      status[s] = sstq_pkg::ST_ARMED;
      if (d <= deadline[head]) begin
        link[s] = head;
        head = s;
        earliest = d;
        return;
      end
      prev = head;
      for (int g = 0; g < 32; g++) begin
        nxt = link[prev];
        if (d <= deadline[nxt]) begin
          link[prev] = s;
          link[s] = nxt;
          return;
        end
        prev = nxt;
      end
    endfunction

    function void note_input(bit [2:0] op, bit [4:0] s, bit [3:0] d, bit [31:0] p,
                             bit [31:0] delay);
      bit        usable;
      bit        granted;
      bit [4:0]  t;
      int        n;
      usable = (s != 0);
      case (op)
        sstq_pkg::OP_TICK: begin
          ticks = ticks + 1;
          if (earliest <= ticks) begin
            t = head;
            n = 0;
            while (t != 0 && n < 31 && deadline[t] <= earliest) begin
              status[t] = sstq_pkg::ST_ALLOC;
              push(sstq_pkg::KIND_EXPIRED, t, dest_mem[t], pay_mem[t], 1'b0);
              n++;
              t = link[t];
            end
            head = t;
            earliest = deadline[t];
            if (n > 0) awaited_q[awaited_q.size() - 1].last = 1'b1;
          end
        end
        sstq_pkg::OP_ALLOC: begin
          granted = 0;
          for (int i = 1; i < 32 && !granted; i++) begin
            if (status[i] == sstq_pkg::ST_FREE) begin
              status[i] = sstq_pkg::ST_ALLOC;
              push(sstq_pkg::KIND_GRANT, i[4:0], 0, 0, 1'b1);
              granted = 1;
            end
          end
          if (!granted) push(sstq_pkg::KIND_NOFREE, 0, 0, 0, 1'b1);
        end
        sstq_pkg::OP_FREE:
          if (usable && status[s] == sstq_pkg::ST_ALLOC) status[s] = sstq_pkg::ST_FREE;
        sstq_pkg::OP_BIND: if (usable) begin
          dest_mem[s] = d;
          pay_mem[s] = p;
        end
        sstq_pkg::OP_ARM:
          if (usable && status[s] != sstq_pkg::ST_ARMED) insert_timer(s, delay);
        default: ;
      endcase
    endfunction

    function void check_result(bit [1:0] k, bit [4:0] s, bit [3:0] d, bit [31:0] p,
                               bit l);
      expiry_t e;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result kind=%0d slot=%0d dest=%0d pay=%h last=%0b",
                   k, s, d, p, l);
        return;
      end
      e = awaited_q.pop_front();
      if (e.kind !== k || e.slot !== s || e.dest !== d || e.pay !== p || e.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind=%0d slot=%0d dest=%0d pay=%h last=%0b, %s",
                   e.kind, e.slot, e.dest, e.pay, e.last,
                   $sformatf("got kind=%0d slot=%0d dest=%0d pay=%h last=%0b",
                             k, s, d, p, l));
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [2:0]         operation = sstq_pkg::OP_TICK;
  logic [4:0]         slot_index = 0;
  logic [3:0]         destination = 0;
  logic signed [31:0] payload = 0;
  logic [31:0]        delay_ticks = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         result_kind;
  logic [4:0]         result_slot;
  logic [3:0]         result_destination;
  logic signed [31:0] result_payload;
  logic               last_of_run;

  timer_scoreboard sb = new();
  bit              idling = 1;
  bit              bound[32];

  sorted_software_timer_queue_top dut (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(result_kind, result_slot, result_destination, result_payload,
                      last_of_run);
    out_stall <= idling && ($urandom_range(99) < 9);
  end

  task automatic send_item(bit [2:0] op, bit [4:0] s, bit [3:0] d = 0, bit [31:0] p = 0,
                           bit [31:0] delay = 0);
    if (idling && $urandom_range(99) < 9) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    slot_index <= s;
    destination <= d;
    payload <= p;
    delay_ticks <= delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, s, d, p, delay);
    if (op == sstq_pkg::OP_BIND && s != 0) bound[s] = 1;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    bit [2:0]  op;
    bit [4:0]  s;
    bit [31:0] delay;
    int        r;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(sstq_pkg::OP_ALLOC, 0);
    send_item(sstq_pkg::OP_ALLOC, 0);
    send_item(sstq_pkg::OP_ALLOC, 0);
    send_item(sstq_pkg::OP_BIND, 1, 4'hf, 32'h7fff_ffff);
    send_item(sstq_pkg::OP_BIND, 2, 4'h0, 32'h8000_0000);
    send_item(sstq_pkg::OP_BIND, 3, 4'h5, 32'hffff_ffff);
    send_item(sstq_pkg::OP_BIND, 0, 4'ha, 32'h1234_5678);
    send_item(sstq_pkg::OP_ARM, 1, 0, 0, 0);
    send_item(sstq_pkg::OP_ARM, 2, 0, 0, 0);
    send_item(sstq_pkg::OP_ARM, 1, 0, 0, 7);
    send_item(sstq_pkg::OP_ARM, 0, 0, 0, 1);
    send_item(sstq_pkg::OP_FREE, 0);
    send_item(sstq_pkg::OP_FREE, 1);
    send_item(sstq_pkg::OP_TICK, 0);
    send_item(sstq_pkg::OP_ARM, 3, 0, 0, 32'hffff_ffff);
    send_item(sstq_pkg::OP_TICK, 0);
    send_item(sstq_pkg::OP_FREE, 3);
    send_item(sstq_pkg::OP_FREE, 3);
    send_item(3'd5, 1);
    send_item(3'd6, 2);
    send_item(3'd7, 31);
    send_item(sstq_pkg::OP_ARM, 2, 0, 0, sstq_pkg::ALL_ONES - sb.ticks);
    send_item(sstq_pkg::OP_ALLOC, 0);
    drain();

    for (int i = 0; i < 420; i++) begin
      idling = !(i >= 150 && i < 250);
      if (i == 300) drain();
      r = $urandom_range(99);
      s = 5'($urandom_range(31));
      if (r < 35) op = sstq_pkg::OP_TICK;
      else if (r < 50) op = sstq_pkg::OP_ALLOC;
      else if (r < 60) op = sstq_pkg::OP_FREE;
      else if (r < 75) op = sstq_pkg::OP_BIND;
      else if (r < 95) op = sstq_pkg::OP_ARM;
      else op = 3'($urandom_range(5, 7));
      if (op == sstq_pkg::OP_ARM && s != 0 && !bound[s]) op = sstq_pkg::OP_BIND;
      r = $urandom_range(99);
      if (r < 3) delay = $urandom;
      else if (r < 5) delay = sstq_pkg::ALL_ONES - sb.ticks;
      else delay = $urandom_range(12);
      send_item(op, s, 4'($urandom), $urandom, delay);
    end
    drain();

    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
